@@ sv/lphs_pkg.sv @@
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants and types of the linear-probing hash set: table geometry,
// field widths, action codes and slot status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   // field widths
   localparam int KEY_W    = 31;
   localparam int BIT_W    = $clog2(KEY_W);
   localparam int CAP_W    = 7;
   localparam int ACTION_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // request actions, the fourth code is a no-op that reports failure
   typedef enum logic [ACTION_W-1:0] {
      ACT_SEARCH = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_ERASE  = 2'd2
   } action_type;

   // slot status codes
   typedef enum logic [1:0] {
      ST_EMPTY   = 2'd0,
      ST_USED    = 2'd1,
      ST_DELETED = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ sv/linear_probe_hash_set.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressed hash set of 31-bit keys with linear probing and tombstones.
// An insert on a full count or an unused action answers on the cycle after
// acceptance. Otherwise the home slot is found one key bit a cycle through a
// shared compare/subtract, then the slot memory read is primed and one slot
// is probed per cycle, at most capacity slots. busy stays high through the
// result cycle; the next item can start on the following cycle. The receiver
// cannot stall.
// Reset: all slots empty (per-slot valid flops), stored count zero,
// capacity 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lphs_pkg::ACTION_W-1:0] req_action,
   input  wire logic [lphs_pkg::KEY_W-1:0]    req_key,
   output logic                               rsp_strobe,
   output logic                               rsp_success,
   input  wire logic                          csr_we,
   input  wire logic [lphs_pkg::CAP_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_HASH  = 4'b0010,
      S_PROBE = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   // control state
   state_type                         state_ff, state_in;
   logic [lphs_pkg::CAP_W-1:0]        cap_ff;
   logic [lphs_pkg::CAP_W-1:0]        count_ff, count_in;
   logic [lphs_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic [lphs_pkg::ADDR_W-1:0]       rem_ff, rem_in;
   logic [lphs_pkg::ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [lphs_pkg::ADDR_W-1:0]       chk_addr_ff;
   logic                              chk_vld_ff, chk_vld_in;
   logic [lphs_pkg::CNT_W-1:0]        probe_cnt_ff, probe_cnt_in;
   logic                              success_ff, success_in;
   logic [lphs_pkg::TABLE_DEPTH-1:0]  slot_vld_ff;

   // item payload
   lphs_pkg::action_type              action_ff, action_in;
   logic [lphs_pkg::KEY_W-1:0]        key_ff, key_in;

   // slot memories and their registered read data
   logic [lphs_pkg::KEY_W-1:0]        key_mem [lphs_pkg::TABLE_DEPTH];
   lphs_pkg::status_type              stat_mem [lphs_pkg::TABLE_DEPTH];
   logic [lphs_pkg::KEY_W-1:0]        rkey_ff;
   lphs_pkg::status_type              rstat_ff;

   // write port controls
   logic                              wr_key_en;
   logic                              wr_stat_en;
   lphs_pkg::status_type              wr_stat;

   // derived values
   logic [lphs_pkg::CNT_W-1:0]        cap_eff;
   logic [lphs_pkg::CNT_W-1:0]        shifted;
   logic [lphs_pkg::CNT_W-1:0]        rd_addr_inc;
   logic [lphs_pkg::ADDR_W-1:0]       rd_addr_nxt;
   logic                              slot_used;
   logic                              slot_match;
   logic                              count_full;
   logic                              last_probe;

   // effective capacity: zero reads as one, saturate at the table depth
   always_comb begin
      if (32'(cap_ff) > lphs_pkg::TABLE_DEPTH) begin
         cap_eff = lphs_pkg::CNT_W'(lphs_pkg::TABLE_DEPTH);
      end else if (cap_ff == '0) begin
         cap_eff = lphs_pkg::CNT_W'(1);
      end else begin
         cap_eff = lphs_pkg::CNT_W'(cap_ff);
      end
   end

   // one restoring remainder step and the wrapping probe address
   assign shifted     = {rem_ff, key_ff[bit_ff]};
   assign rd_addr_inc = {1'b0, rd_addr_ff} + lphs_pkg::CNT_W'(1);
   assign rd_addr_nxt = (rd_addr_inc == cap_eff) ? '0 : rd_addr_inc[lphs_pkg::ADDR_W-1:0];

   // slot compare on the registered read data
   assign slot_used  = (rstat_ff == lphs_pkg::ST_USED);
   assign slot_match = slot_used && (rkey_ff == key_ff);
   assign count_full = (32'(count_ff) >= 32'(cap_eff));
   assign last_probe = ((probe_cnt_ff + lphs_pkg::CNT_W'(1)) == cap_eff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      rd_addr_in   = rd_addr_ff;
      chk_vld_in   = 1'b0;
      probe_cnt_in = probe_cnt_ff;
      success_in   = success_ff;
      wr_key_en    = 1'b0;
      wr_stat_en   = 1'b0;
      wr_stat      = lphs_pkg::ST_USED;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in  = lphs_pkg::action_type'(req_action);
               key_in     = req_key;
               rem_in     = '0;
               bit_in     = lphs_pkg::BIT_W'(lphs_pkg::KEY_W - 1);
               success_in = 1'b0;
               case (lphs_pkg::action_type'(req_action))
                  lphs_pkg::ACT_SEARCH,
                  lphs_pkg::ACT_ERASE: state_in = S_HASH;
                  lphs_pkg::ACT_INSERT: begin
                     state_in = count_full ? S_RESP : S_HASH;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         // home slot = key mod capacity, msb first
         S_HASH: begin
            if (shifted >= cap_eff) begin
               rem_in = lphs_pkg::ADDR_W'(shifted - cap_eff);
            end else begin
               rem_in = lphs_pkg::ADDR_W'(shifted);
            end
            bit_in = bit_ff - lphs_pkg::BIT_W'(1);
            if (bit_ff == '0) begin
               rd_addr_in   = rem_in;
               probe_cnt_in = '0;
               state_in     = S_PROBE;
            end
         end

         // reads run one slot ahead of the compare
         S_PROBE: begin
            rd_addr_in = rd_addr_nxt;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               probe_cnt_in = probe_cnt_ff + lphs_pkg::CNT_W'(1);
               if (action_ff == lphs_pkg::ACT_INSERT) begin
                  if (slot_match) begin
                     success_in = 1'b0;
                     state_in   = S_RESP;
                  end else if (!slot_used) begin
                     wr_key_en  = 1'b1;
                     wr_stat_en = 1'b1;
                     wr_stat    = lphs_pkg::ST_USED;
                     count_in   = count_ff + lphs_pkg::CAP_W'(1);
                     success_in = 1'b1;
                     state_in   = S_RESP;
                  end else if (last_probe) begin
                     success_in = 1'b0;
                     state_in   = S_RESP;
                  end
               end else begin
                  if (rstat_ff == lphs_pkg::ST_EMPTY) begin
                     success_in = 1'b0;
                     state_in   = S_RESP;
                  end else if (slot_match) begin
                     wr_stat_en = (action_ff == lphs_pkg::ACT_ERASE);
                     wr_stat    = lphs_pkg::ST_DELETED;
                     success_in = 1'b1;
                     state_in   = S_RESP;
                  end else if (last_probe) begin
                     success_in = 1'b0;
                     state_in   = S_RESP;
                  end
               end
               if (state_in == S_RESP) begin
                  chk_vld_in = 1'b0;
               end
            end
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= lphs_pkg::CAP_RESET;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         probe_cnt_ff <= '0;
         bit_ff       <= '0;
         rem_ff       <= '0;
         rd_addr_ff   <= '0;
         success_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         probe_cnt_ff <= probe_cnt_in;
         bit_ff       <= bit_in;
         rem_ff       <= rem_in;
         rd_addr_ff   <= rd_addr_in;
         success_ff   <= success_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
   end

   // per-slot valid flags: a slot never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (wr_stat_en) begin
         slot_vld_ff[chk_addr_ff] <= 1'b1;
      end
   end

   // slot memory writes
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[chk_addr_ff] <= key_ff;
      end
      if (wr_stat_en) begin
         stat_mem[chk_addr_ff] <= wr_stat;
      end
   end

   // slot memory reads, registered
   always_ff @(posedge clock) begin
      rkey_ff     <= key_mem[rd_addr_ff];
      rstat_ff    <= slot_vld_ff[rd_addr_ff] ? stat_mem[rd_addr_ff] : lphs_pkg::ST_EMPTY;
      chk_addr_ff <= rd_addr_ff;
   end

   // outputs
   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = (state_ff == S_RESP);
   assign rsp_success = success_ff;

endmodule

`default_nettype wire
